// ----- rtl/core/fbpa_pkg.sv -----
// shared types and constants for the fixed block pool allocator
// used by the channel interfaces, the controller, the datapath and the top level
package fbpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int BYTES_W    = 16;
	localparam int CNT_OUT_W  = 9;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register values after reset
	localparam logic [ADDR_W-1:0]    BASE_RST   = '0;
	localparam logic [BYTES_W-1:0]   BYTES_RST  = 16'd32;
	localparam logic [CNT_OUT_W-1:0] BLOCKS_RST = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_POOL_BASE      = 2'd0,
		REG_BLOCK_BYTES    = 2'd1,
		REG_BLOCKS_IN_POOL = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_BOOT,
		S_FILL,
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    pop;
		logic    push;
		logic    fill_start;
		logic    fill_step;
		logic    load_out;
		logic    grant;
		status_t out_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             full;
		logic             fill_last;
	} dp_stat_t;

endpackage

// ----- rtl/core/fbpa_if.sv -----
// valid/ready channel interfaces for the block pool allocator
// depends on fbpa_pkg for field widths and the status type
interface fbpa_req_if import fbpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [ADDR_W-1:0]   freed_address;

	modport source (output valid, command, freed_address, input ready);
	modport sink (input valid, command, freed_address, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADDR_W-1:0]    granted_address;
	status_t              status;
	logic [CNT_OUT_W-1:0] blocks_free;

	modport source (output valid, granted_address, status, blocks_free, input ready);
	modport sink (input valid, granted_address, status, blocks_free, output ready);
endinterface

// ----- rtl/core/fbpa_ctrl.sv -----
// controller state machine for the block pool allocator
// sequences accept, execute and fill sweeps; depends on fbpa_pkg
module fbpa_ctrl import fbpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next     = state_q;
		req_ready      = 1'b0;
		ctl            = '0;
		ctl.out_status = ST_OK;
		case (state_q)
			S_BOOT, S_FILL: begin
				ctl.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_next = (state_q == S_BOOT) ? S_IDLE : S_DONE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.capture = 1'b1;
					state_next  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_t'(stat.cmd))
					CMD_ALLOC: begin
						if (out_free) begin
							ctl.load_out = 1'b1;
							if (stat.empty) begin
								ctl.out_status = ST_EMPTY;
							end else begin
								ctl.pop   = 1'b1;
								ctl.grant = 1'b1;
							end
							state_next = S_IDLE;
						end
					end
					CMD_FREE: begin
						if (out_free) begin
							ctl.load_out = 1'b1;
							if (stat.full) begin
								ctl.out_status = ST_FULL;
							end else begin
								ctl.push = 1'b1;
							end
							state_next = S_IDLE;
						end
					end
					CMD_INIT: begin
						ctl.fill_start = 1'b1;
						state_next     = S_FILL;
					end
					default: begin
						// unused code, plain ok result
						if (out_free) begin
							ctl.load_out = 1'b1;
							state_next   = S_IDLE;
						end
					end
				endcase
			end
			S_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/fbpa_dp.sv -----
// datapath for the block pool allocator: config registers, free stack memory,
// stack pointer, fill sweep address generator and result registers; uses fbpa_pkg
module fbpa_dp import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic [CMD_W-1:0]      command,
	input  logic [ADDR_W-1:0]     freed_address,
	input  dp_cmd_t               ctl,
	output dp_stat_t              stat,
	output logic [ADDR_W-1:0]     granted_address,
	output status_t               status,
	output logic [CNT_OUT_W-1:0]  blocks_free
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] CNT_RST = (int'(BLOCKS_RST) > MAX_BLOCKS) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(BLOCKS_RST);

	// configuration registers
	logic [ADDR_W-1:0]    base_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [CNT_OUT_W-1:0] blocks_q;

	// stack control and fill sweep
	logic [CNT_W-1:0]   top_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   fill_idx_q;
	logic [ADDR_W-1:0]  fill_addr_q;
	logic [BYTES_W-1:0] step_q;

	// captured request and memory read data
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [ADDR_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] mem_q [MAX_BLOCKS];

	// result registers
	logic [ADDR_W-1:0]    granted_q;
	status_t              status_q;
	logic [CNT_OUT_W-1:0] free_q;

	logic [CNT_W-1:0]           blocks_sat;
	logic [CNT_W-1:0]           top_next;
	logic [CNT_W-1:0]           top_dec;
	logic [CNT_W+CNT_OUT_W-1:0] top_ext;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_wa;
	logic [ADDR_W-1:0]          mem_wd;

	assign blocks_sat = (32'(blocks_q) > 32'(MAX_BLOCKS)) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_q);
	assign top_dec = top_q - CNT_W'(1);
	assign top_ext = (CNT_W + CNT_OUT_W)'(top_next);

	always_comb begin
		top_next = top_q;
		if (ctl.pop) begin
			top_next = top_dec;
		end else if (ctl.push) begin
			top_next = top_q + CNT_W'(1);
		end
	end

	// one write port shared by push and fill sweep
	assign mem_we = ctl.push || (ctl.fill_step && (fill_idx_q < limit_q));
	assign mem_wa = ctl.push ? top_q[IDX_W-1:0] : fill_idx_q[IDX_W-1:0];
	assign mem_wd = ctl.push ? faddr_q : fill_addr_q;

	assign stat.cmd       = cmd_q;
	assign stat.empty     = (top_q == '0);
	assign stat.full      = (top_q >= limit_q);
	assign stat.fill_last = ((fill_idx_q + CNT_W'(1)) >= limit_q);

	assign granted_address = granted_q;
	assign status          = status_q;
	assign blocks_free     = free_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		// top entry is read on accept so a pop in the execute state has it
		if (ctl.capture) begin
			rd_data_q <= mem_q[top_dec[IDX_W-1:0]];
			cmd_q     <= command;
			faddr_q   <= freed_address;
		end
		if (ctl.load_out) begin
			granted_q <= ctl.grant ? rd_data_q : '0;
			status_q  <= ctl.out_status;
			free_q    <= top_ext[CNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RST;
			bytes_q     <= BYTES_RST;
			blocks_q    <= BLOCKS_RST;
			top_q       <= CNT_RST;
			limit_q     <= CNT_RST;
			fill_idx_q  <= '0;
			fill_addr_q <= BASE_RST;
			step_q      <= BYTES_RST;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_POOL_BASE:      base_q   <= wr_data[ADDR_W-1:0];
					REG_BLOCK_BYTES:    bytes_q  <= wr_data[BYTES_W-1:0];
					REG_BLOCKS_IN_POOL: blocks_q <= wr_data[CNT_OUT_W-1:0];
					default: ;
				endcase
			end
			if (ctl.fill_start) begin
				// sweep uses the register values latched here
				fill_addr_q <= base_q;
				step_q      <= bytes_q;
				limit_q     <= blocks_sat;
				top_q       <= blocks_sat;
				fill_idx_q  <= '0;
			end else begin
				if (ctl.fill_step) begin
					fill_idx_q  <= fill_idx_q + CNT_W'(1);
					fill_addr_q <= fill_addr_q + ADDR_W'(step_q);
				end
				top_q <= top_next;
			end
		end
	end

`ifndef SYNTH
	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= limit_q)
		else $error("stack pointer above pool limit");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full)
		else $error("push issued on a full stack");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.empty)
		else $error("pop issued on an empty stack");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> top_q == $past(top_q) - CNT_W'(1))
		else $error("pop did not move the stack pointer down by one");
`endif

endmodule

// ----- rtl/core/fixed_block_pool_allocator_core.sv -----
// fixed block pool allocator: free block addresses kept on a lifo stack in one memory
// allocate/free: a request is captured on acceptance, then executed into the result
// registers; no new request is taken until then, and execute stalls on a pending result
// reinitialize: refills the stack from the registers, one memory entry written per cycle
// after arst_n the stack is filled from the reset register values, one entry per cycle;
// no request is taken until the sweep is done
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fbpa_req_if.sink              req,
	fbpa_rsp_if.source            rsp,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.command         (req.command),
		.freed_address   (req.freed_address),
		.ctl             (ctl),
		.stat            (stat),
		.granted_address (rsp.granted_address),
		.status          (rsp.status),
		.blocks_free     (rsp.blocks_free)
	);

endmodule
